// File: src/assert_macros.svh
// Concurrent assertion helpers, sampled on clk_i, off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SKIT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define SKIT_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: src/skit_pkg.sv
`default_nettype none

package skit_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefKeyBits    = 64;
  localparam int DefOffsetBits = 32;

  localparam int CmdW    = 2;
  localparam int KeyW    = 64;
  localparam int OffW    = 32;
  localparam int StatusW = 2;
  localparam int FieldW  = 7;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_UPDATE = 2'd2;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic lt;
    logic key_eq;
    logic key_ge;
    logic off_eq;
  } cmp_t;

endpackage

`default_nettype wire

// File: src/sorted_key_index_table_unit.sv
// channel | dir | handshake               | beat
// --------+-----+-------------------------+---------------------------------------------
// in      | in  | in_valid_i / in_ready_o | command_i, key_i, offset_i
// out     | out | out_valid_o / out_ready_i | status_o, position_o, match_count_o,
//         |     |                         | entry_count_o
//
// One table entry is read per cycle from the single table RAM; that read port sets the time.
// A delete or update whose offset is missing ends with not-found status and leaves the
// table as it was.
// Reset clears the entry count, sequencer and output valid; table contents stay unknown.
// A finished beat waits in the output register while the next command is taken.
// A command that finishes while the output register is still full holds until it drains.
`default_nettype none
`include "assert_macros.svh"

module sorted_key_index_table_unit #(
  parameter int TABLE_DEPTH = skit_pkg::DefTableDepth,
  parameter int KEY_BITS    = skit_pkg::DefKeyBits,
  parameter int OFFSET_BITS = skit_pkg::DefOffsetBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [skit_pkg::CmdW-1:0]     command_i,
  input  wire logic [skit_pkg::KeyW-1:0]     key_i,
  input  wire logic [skit_pkg::OffW-1:0]     offset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [skit_pkg::StatusW-1:0]  status_o,
  output logic      [skit_pkg::FieldW-1:0]   position_o,
  output logic      [skit_pkg::FieldW-1:0]   match_count_o,
  output logic      [skit_pkg::FieldW-1:0]   entry_count_o
);

  import skit_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int OW = (OFFSET_BITS > OffW) ? OffW : OFFSET_BITS;
  localparam int EW = KEY_BITS + OW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DEL    = 3'd1;
  localparam logic [2:0] S_INS_GO = 3'd2;
  localparam logic [2:0] S_INS    = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_LKP    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [CmdW-1:0]     cmd_q;
  logic [KEY_BITS-1:0] key_q;
  logic [OW-1:0]       off_q;
  logic [CW-1:0]       n_q, n_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                found_q, found_d;
  logic [StatusW-1:0]  st_q, st_d;
  logic                out_valid_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  cmp_t cmp;
  logic accept;
  logic last;
  logic go_on;
  logic fin_load;

  skit_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  skit_cmp #(
    .KEY_BITS    (KEY_BITS),
    .OFFSET_WIDTH(OW)
  ) u_cmp (
    .key_a_i(key_q),
    .off_a_i(off_q),
    .key_b_i(ram_rdata[EW-1:OW]),
    .off_b_i(ram_rdata[OW-1:0]),
    .cmp_o  (cmp)
  );

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (CW'(idx_q) + CW'(1)) == n_q;
  assign fin_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    st_d      = st_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    go_on     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          found_d = 1'b0;
          cnt_d   = '0;
          pos_d   = '0;
          st_d    = ST_DONE;
          if (command_i == CMD_INSERT) begin
            if (n_q == CW'(TABLE_DEPTH)) begin
              st_d    = ST_FULL;
              state_d = S_FIN;
            end else if (n_q == '0) begin
              state_d = S_PUT;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(n_q - CW'(1));
              idx_d     = AW'(n_q - CW'(1));
              state_d   = S_INS;
            end
          end else if (n_q == '0) begin
            st_d    = ST_NOT_FOUND;
            state_d = S_FIN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = (command_i == CMD_LOOKUP) ? S_LKP : S_DEL;
          end
        end
      end
      S_DEL: begin
        if (found_q) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q - AW'(1);
        end else if (cmp.off_eq) begin
          found_d = 1'b1;
          pos_d   = idx_q;
        end
        if (last) begin
          if (found_d) begin
            n_d     = n_q - CW'(1);
            state_d = (cmd_q == CMD_UPDATE) ? S_INS_GO : S_FIN;
          end else begin
            st_d    = ST_NOT_FOUND;
            state_d = S_FIN;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end
      S_INS_GO: begin
        if (n_q == '0) begin
          pos_d   = '0;
          state_d = S_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(n_q - CW'(1));
          idx_d     = AW'(n_q - CW'(1));
          state_d   = S_INS;
        end
      end
      S_INS: begin
        if (cmp.lt) begin
          ram_we    = 1'b1;
          ram_waddr = idx_q + AW'(1);
          if (idx_q == '0) begin
            pos_d   = '0;
            state_d = S_PUT;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
            idx_d     = idx_q - AW'(1);
          end
        end else begin
          pos_d   = idx_q + AW'(1);
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {key_q, off_q};
        n_d       = n_q + CW'(1);
        state_d   = S_FIN;
      end
      S_LKP: begin
        if (!found_q) begin
          if (cmp.key_ge && !cmp.key_eq) begin
            go_on = 1'b1;
          end else if (cmp.key_eq) begin
            found_d = 1'b1;
            pos_d   = idx_q;
            cnt_d   = CW'(1);
            go_on   = 1'b1;
          end
        end else if (cmp.key_eq) begin
          cnt_d = cnt_q + CW'(1);
          go_on = 1'b1;
        end
        if (go_on && !last) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end else begin
          if (!found_d) begin
            st_d = ST_NOT_FOUND;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      found_q <= found_d;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    cnt_q <= cnt_d;
    st_q  <= st_d;
    if (accept) begin
      cmd_q <= command_i;
      key_q <= key_i[KEY_BITS-1:0];
      off_q <= offset_i[OW-1:0];
    end
    if (fin_load) begin
      status_o      <= st_q;
      position_o    <= FieldW'(pos_q);
      match_count_o <= FieldW'(cnt_q);
      entry_count_o <= FieldW'(n_q);
    end
  end

  assign out_valid_o = out_valid_q;

  `SKIT_ASSERT(a_count_range, n_q <= CW'(TABLE_DEPTH), "entry count beyond table depth")
  `SKIT_ASSERT_IMP(a_idle_no_write, state_q == S_IDLE, !ram_we, "table write while idle")
  `SKIT_ASSERT_IMP(a_out_from_fin, $rose(out_valid_o), $past(state_q) == S_FIN,
                   "result beat without finished command")
  `SKIT_ASSERT_IMP(a_count_source, n_q != $past(n_q),
                   $past(state_q) == S_DEL || $past(state_q) == S_PUT,
                   "entry count changed outside delete or place")

endmodule

`default_nettype wire

// File: src/skit_ram.sv
`default_nettype none

module skit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/skit_cmp.sv
`default_nettype none

module skit_cmp #(
  parameter int KEY_BITS     = 64,
  parameter int OFFSET_WIDTH = 32
) (
  input  wire logic [KEY_BITS-1:0]     key_a_i,
  input  wire logic [OFFSET_WIDTH-1:0] off_a_i,
  input  wire logic [KEY_BITS-1:0]     key_b_i,
  input  wire logic [OFFSET_WIDTH-1:0] off_b_i,
  output skit_pkg::cmp_t               cmp_o
);

  import skit_pkg::*;

  logic key_lt;
  logic key_eq;

  assign key_lt = key_a_i < key_b_i;
  assign key_eq = key_a_i == key_b_i;

  assign cmp_o.lt     = key_lt || (key_eq && (off_a_i < off_b_i));
  assign cmp_o.key_eq = key_eq;
  assign cmp_o.key_ge = !key_lt;
  assign cmp_o.off_eq = off_a_i == off_b_i;

endmodule

`default_nettype wire
